// ===== src/rpt_pkg.sv =====
`timescale 1ns / 1ps

package rpt_pkg;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  localparam int FracBits = 14;
  localparam logic signed [31:0] RoundHalf = 32'sd8192;
  localparam logic signed [17:0] CoordMax = 18'sd32767;
  localparam logic signed [17:0] CoordMin = -18'sd32768;

  localparam longint PiQ30 = 64'sd3373259426;
  localparam longint OneQ30 = 64'sd1073741824;

endpackage

// ===== src/rpt_point_if.sv =====
`timescale 1ns / 1ps

interface rpt_point_if;
  logic valid;
  logic ready;
  rpt_pkg::coord_t radius;
  rpt_pkg::coord_t height;
  logic first_point;

  modport source (output valid, radius, height, first_point, input ready);
  modport sink (input valid, radius, height, first_point, output ready);
endinterface

// ===== src/rpt_tri_if.sv =====
`timescale 1ns / 1ps

interface rpt_tri_if;
  logic valid;
  logic ready;
  rpt_pkg::coord_t a_x;
  rpt_pkg::coord_t a_y;
  rpt_pkg::coord_t a_z;
  rpt_pkg::coord_t b_x;
  rpt_pkg::coord_t b_y;
  rpt_pkg::coord_t b_z;
  rpt_pkg::coord_t c_x;
  rpt_pkg::coord_t c_y;
  rpt_pkg::coord_t c_z;
  logic band_end;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, band_end,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, band_end,
                output ready);
endinterface

// ===== src/revolved_profile_triangulator.sv =====
`timescale 1ns / 1ps

// Sweeps a profile of (radius, height) points in signed Q8.8 about the z axis. A point
// that closes a band gives 2*DIVISIONS triangles, one per cycle from the output
// register while triangles.ready does not stall it, and the block stays busy until the
// last of them is loaded; the next point is taken in the same cycle as the last
// triangle of the band is loaded, so bands run back to back. A point that opens a
// profile gives no triangle and is stored without making the block busy. The output
// register is fed by six 16x16 multipliers on a sine/cosine table of 2*DIVISIONS
// half-step entries in Q1.14 that is fixed at elaboration. band_end marks the last triangle of each band.
module revolved_profile_triangulator #(
  parameter int DIVISIONS = 8
) (
  input logic clk,
  input logic rst,
  rpt_point_if.sink points,
  rpt_tri_if.source triangles
);

  localparam int STEPS = 2 * DIVISIONS;
  localparam int IDX_W = $clog2(STEPS);

  // quarter-wave taylor series in q30, mapped to its quadrant, rounded to q1.14
  function automatic rpt_pkg::coord_t tab_entry(input int t, input bit want_cos);
    int q;
    int r;
    longint x;
    longint unsigned xu;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint cs;
    longint sc;
    longint cc;
    rpt_pkg::coord_t s14;
    rpt_pkg::coord_t c14;
    rpt_pkg::coord_t sv;
    rpt_pkg::coord_t cv;
    q = (2 * t) / DIVISIONS;
    r = 2 * t - q * DIVISIONS;
    x = (rpt_pkg::PiQ30 * longint'(r)) / STEPS;
    xu = longint'(x);
    x2 = (xu * xu) >> 30;
    ts = xu;
    tc = rpt_pkg::OneQ30;
    ss = x;
    cs = rpt_pkg::OneQ30;
    ts = ((ts * x2) / 6) >> 30;   tc = ((tc * x2) / 2) >> 30;
    ss -= longint'(ts);           cs -= longint'(tc);
    ts = ((ts * x2) / 20) >> 30;  tc = ((tc * x2) / 12) >> 30;
    ss += longint'(ts);           cs += longint'(tc);
    ts = ((ts * x2) / 42) >> 30;  tc = ((tc * x2) / 30) >> 30;
    ss -= longint'(ts);           cs -= longint'(tc);
    ts = ((ts * x2) / 72) >> 30;  tc = ((tc * x2) / 56) >> 30;
    ss += longint'(ts);           cs += longint'(tc);
    ts = ((ts * x2) / 110) >> 30; tc = ((tc * x2) / 90) >> 30;
    ss -= longint'(ts);           cs -= longint'(tc);
    ts = ((ts * x2) / 156) >> 30; tc = ((tc * x2) / 132) >> 30;
    ss += longint'(ts);           cs += longint'(tc);
    ts = ((ts * x2) / 210) >> 30; tc = ((tc * x2) / 182) >> 30;
    ss -= longint'(ts);           cs -= longint'(tc);
    ts = ((ts * x2) / 272) >> 30; tc = ((tc * x2) / 240) >> 30;
    ss += longint'(ts);           cs += longint'(tc);
    ts = ((ts * x2) / 342) >> 30; tc = ((tc * x2) / 306) >> 30;
    ss -= longint'(ts);           cs -= longint'(tc);
    sc = (ss < 0) ? 64'sd0 : ((ss > rpt_pkg::OneQ30) ? rpt_pkg::OneQ30 : ss);
    cc = (cs < 0) ? 64'sd0 : ((cs > rpt_pkg::OneQ30) ? rpt_pkg::OneQ30 : cs);
    s14 = 16'((sc + 64'sd32768) >>> 16);
    c14 = 16'((cc + 64'sd32768) >>> 16);
    case (q % 4)
      0: begin
        sv = s14;
        cv = c14;
      end
      1: begin
        sv = c14;
        cv = -s14;
      end
      2: begin
        sv = -s14;
        cv = -c14;
      end
      default: begin
        sv = -c14;
        cv = s14;
      end
    endcase
    return want_cos ? cv : sv;
  endfunction

  // q8.8 times q1.14, rounded half up and saturated
  function automatic rpt_pkg::coord_t scale(input rpt_pkg::coord_t r, input rpt_pkg::coord_t t);
    logic signed [31:0] p;
    logic signed [17:0] v;
    rpt_pkg::coord_t res;
    p = 32'(r) * 32'(t) + rpt_pkg::RoundHalf;
    v = 18'(p >>> rpt_pkg::FracBits);
    if (v > rpt_pkg::CoordMax) begin
      res = 16'(rpt_pkg::CoordMax);
    end else if (v < rpt_pkg::CoordMin) begin
      res = 16'(rpt_pkg::CoordMin);
    end else begin
      res = 16'(v);
    end
    return res;
  endfunction

  // angle index 2*j + parity of the previous point, j = m + inc
  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-2:0] m, input logic inc,
                                                 input logic par);
    logic [IDX_W-1:0] j;
    logic [IDX_W:0] e;
    j = IDX_W'(m) + IDX_W'(inc);
    e = {j, par};
    if (e >= (IDX_W + 1)'(STEPS)) begin
      e = e - (IDX_W + 1)'(STEPS);
    end
    return e[IDX_W-1:0];
  endfunction

  // the current point sits one half step behind
  function automatic logic [IDX_W-1:0] cur_idx(input logic [IDX_W-1:0] pi);
    return (pi == '0) ? IDX_W'(STEPS - 1) : pi - 1'b1;
  endfunction

  rpt_pkg::coord_t sin_tab [STEPS];
  rpt_pkg::coord_t cos_tab [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_tab
    localparam rpt_pkg::coord_t SinVal = tab_entry(g, 1'b0);
    localparam rpt_pkg::coord_t CosVal = tab_entry(g, 1'b1);
    assign sin_tab[g] = SinVal;
    assign cos_tab[g] = CosVal;
  end

  rpt_pkg::coord_t prev_radius;
  rpt_pkg::coord_t prev_height;
  logic have_previous;
  logic band_parity;

  rpt_pkg::coord_t work_prev_r;
  rpt_pkg::coord_t work_prev_h;
  rpt_pkg::coord_t work_cur_r;
  rpt_pkg::coord_t work_cur_h;
  logic work_parity;
  logic busy;
  logic [IDX_W-1:0] k;

  logic accept;
  logic emit;
  logic advance;
  logic last_step;
  logic odd;
  logic [IDX_W-2:0] m;
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  logic [IDX_W-1:0] idx_c;
  rpt_pkg::coord_t c_r;
  rpt_pkg::coord_t c_h;
  rpt_pkg::vertex_t va;
  rpt_pkg::vertex_t vb;
  rpt_pkg::vertex_t vc;

  assign last_step = (k == IDX_W'(STEPS - 1));
  assign advance = busy && (!triangles.valid || triangles.ready);
  assign points.ready = !busy || (advance && last_step);
  assign accept = points.valid && points.ready;
  assign emit = !points.first_point && have_previous;

  assign odd = k[0];
  assign m = k[IDX_W-1:1];

  always_comb begin
    idx_a = prev_idx(m, odd, work_parity);
    idx_b = cur_idx(idx_a);
    if (odd) begin
      idx_c = prev_idx(m, 1'b0, work_parity);
      c_r = work_prev_r;
      c_h = work_prev_h;
    end else begin
      idx_c = cur_idx(prev_idx(m, 1'b1, work_parity));
      c_r = work_cur_r;
      c_h = work_cur_h;
    end
    va = '{x: scale(work_prev_r, sin_tab[idx_a]), y: scale(work_prev_r, cos_tab[idx_a]),
           z: work_prev_h};
    vb = '{x: scale(work_cur_r, sin_tab[idx_b]), y: scale(work_cur_r, cos_tab[idx_b]),
           z: work_cur_h};
    vc = '{x: scale(c_r, sin_tab[idx_c]), y: scale(c_r, cos_tab[idx_c]), z: c_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_radius <= '0;
      prev_height <= '0;
      have_previous <= 1'b0;
      band_parity <= 1'b0;
      busy <= 1'b0;
      k <= '0;
    end else begin
      if (accept && emit) begin
        busy <= 1'b1;
        k <= '0;
      end else if (advance) begin
        k <= k + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        prev_radius <= points.radius;
        prev_height <= points.height;
        have_previous <= 1'b1;
        if (emit) begin
          band_parity <= ~band_parity;
        end else begin
          band_parity <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      work_prev_r <= prev_radius;
      work_prev_h <= prev_height;
      work_cur_r <= points.radius;
      work_cur_h <= points.height;
      work_parity <= band_parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triangles.valid <= 1'b0;
    end else if (advance) begin
      triangles.valid <= 1'b1;
    end else if (triangles.ready) begin
      triangles.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      triangles.a_x <= va.x;
      triangles.a_y <= va.y;
      triangles.a_z <= va.z;
      triangles.b_x <= vb.x;
      triangles.b_y <= vb.y;
      triangles.b_z <= vb.z;
      triangles.c_x <= vc.x;
      triangles.c_y <= vc.y;
      triangles.c_z <= vc.z;
      triangles.band_end <= last_step;
    end
  end

  a_band_start: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> busy && k == '0)
    else $error("band did not start after transaction");

  a_prev_kept: assert property (@(posedge clk) disable iff (rst)
    have_previous |=> have_previous)
    else $error("previous point lost");

  a_band_end: assert property (@(posedge clk) disable iff (rst)
    advance |=> triangles.valid && triangles.band_end == $past(last_step))
    else $error("band_end out of step with slice counter");

  a_prev_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> prev_radius == $past(points.radius) && prev_height == $past(points.height))
    else $error("previous point not updated");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int Divisions = 8;
  localparam int Steps = 2 * Divisions;
  localparam int SettleCycles = 4 * Steps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    rpt_pkg::vertex_t a;
    rpt_pkg::vertex_t b;
    rpt_pkg::vertex_t c;
    logic band_end;
  } facet_t;

  class band_checker;
    int sin_q14[Steps];
    int cos_q14[Steps];
    rpt_pkg::coord_t prev_radius;
    rpt_pkg::coord_t prev_height;
    bit have_prev;
    bit parity;
    facet_t pending_facets[$];
    int errors;

    function new();
      build_angle_table();
      prev_radius = '0;
      prev_height = '0;
      have_prev = 1'b0;
      parity = 1'b0;
      errors = 0;
    endfunction

    function void taylor_q30(longint x, output longint s, output longint c);
      u64_t x2, ts, tc;
      x2 = (u64_t'(x) * u64_t'(x)) >> 30;
      ts = u64_t'(x);
      tc = u64_t'(rpt_pkg::OneQ30);
      s = x;
      c = rpt_pkg::OneQ30;
      for (int n = 1; n <= 9; n++) begin
        ts = ts * x2 / u64_t'((2 * n) * (2 * n + 1));
        ts = ts >> 30;
        tc = tc * x2 / u64_t'((2 * n - 1) * (2 * n));
        tc = tc >> 30;
        if (n % 2 == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
    endfunction

    function int to_q14(longint v);
      if (v < 0) v = 0;
      if (v > rpt_pkg::OneQ30) v = rpt_pkg::OneQ30;
      return int'((v + 32768) >>> 16);
    endfunction

    function void build_angle_table();
      int q, r, s14, c14;
      longint x, s, c;
      for (int t = 0; t < Steps; t++) begin
        q = (2 * t) / Divisions;
        r = 2 * t - q * Divisions;
        x = rpt_pkg::PiQ30 * r / (2 * Divisions);
        taylor_q30(x, s, c);
        s14 = to_q14(s);
        c14 = to_q14(c);
        case (q % 4)
          0: begin sin_q14[t] = s14; cos_q14[t] = c14; end
          1: begin sin_q14[t] = c14; cos_q14[t] = -s14; end
          2: begin sin_q14[t] = -s14; cos_q14[t] = -c14; end
          default: begin sin_q14[t] = -c14; cos_q14[t] = s14; end
        endcase
      end
    endfunction

    function rpt_pkg::coord_t scale(rpt_pkg::coord_t r, int t);
      longint p;
      p = (longint'(r) * t + 8192) >>> 14;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return rpt_pkg::coord_t'(p);
    endfunction

    function rpt_pkg::vertex_t swept_vertex(rpt_pkg::coord_t r, rpt_pkg::coord_t h, int idx);
      rpt_pkg::vertex_t v;
      int k;
      k = idx % Steps;
      v.x = scale(r, sin_q14[k]);
      v.y = scale(r, cos_q14[k]);
      v.z = h;
      return v;
    endfunction

    // a closing point yields the band's triangles; an opening point is just stored
    function void note_point(rpt_pkg::coord_t r, rpt_pkg::coord_t h, logic first);
      rpt_pkg::vertex_t lp, lq, np, nq;
      int p;
      if (first || !have_prev) begin
        prev_radius = r;
        prev_height = h;
        have_prev = 1'b1;
        parity = 1'b0;
        return;
      end
      p = int'(parity);
      lp = swept_vertex(prev_radius, prev_height, p);
      lq = swept_vertex(r, h, p + Steps - 1);
      for (int i = 1; i <= Divisions; i++) begin
        np = swept_vertex(prev_radius, prev_height, 2 * i + p);
        nq = swept_vertex(r, h, 2 * i + p + Steps - 1);
        pending_facets.push_back('{lp, lq, nq, 1'b0});
        pending_facets.push_back('{np, nq, lp, (i == Divisions)});
        lp = np;
        lq = nq;
      end
      parity = ~parity;
      prev_radius = r;
      prev_height = h;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_vertex(string tag, rpt_pkg::vertex_t got, rpt_pkg::vertex_t want);
      if (got.x !== want.x)
        report_mismatch($sformatf("%s_x got %0d want %0d", tag, got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("%s_y got %0d want %0d", tag, got.y, want.y));
      if (got.z !== want.z)
        report_mismatch($sformatf("%s_z got %0d want %0d", tag, got.z, want.z));
    endtask

    task check_facet(facet_t got);
      facet_t want;
      if (pending_facets.size() == 0) begin
        report_mismatch("triangle transaction with none outstanding");
        return;
      end
      want = pending_facets.pop_front();
      check_vertex("a", got.a, want.a);
      check_vertex("b", got.b, want.b);
      check_vertex("c", got.c, want.c);
      if (got.band_end !== want.band_end)
        report_mismatch($sformatf("band_end got %0b want %0b", got.band_end, want.band_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int idle_pct = 0;
  int stall_pct = 0;
  band_checker sb;

  rpt_point_if points();
  rpt_tri_if triangles();

  revolved_profile_triangulator #(.DIVISIONS(Divisions)) dut (
    .clk(clk),
    .rst(rst),
    .points(points),
    .triangles(triangles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    triangles.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && triangles.valid && triangles.ready)
      sb.check_facet({triangles.a_x, triangles.a_y, triangles.a_z,
                      triangles.b_x, triangles.b_y, triangles.b_z,
                      triangles.c_x, triangles.c_y, triangles.c_z,
                      triangles.band_end});
  end

  function automatic rpt_pkg::coord_t rand_coord();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return rpt_pkg::coord_t'(-32768);
        1: return rpt_pkg::coord_t'(32767);
        2: return rpt_pkg::coord_t'(0);
        3: return rpt_pkg::coord_t'(-1);
        default: return rpt_pkg::coord_t'(1);
      endcase
    end
    return rpt_pkg::coord_t'($urandom);
  endfunction

  task automatic send_point(rpt_pkg::coord_t r, rpt_pkg::coord_t h, logic first);
    while ($urandom_range(99) < idle_pct) begin
      points.valid = 1'b0;
      @(negedge clk);
    end
    points.valid = 1'b1;
    points.radius = r;
    points.height = h;
    points.first_point = first;
    do @(posedge clk); while (!points.ready);
    sb.note_point(r, h, first);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    points.valid = 1'b0;
    while (sb.pending_facets.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_profiles(int n_items, bit pause_midway);
    int sent, len;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (pause_midway && !paused && sent >= n_items / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        send_point(rand_coord(), rand_coord(), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(6, 1);
        send_point(rand_coord(), rand_coord(), 1'b1);
        sent++;
        repeat (len) begin
          send_point(rand_coord(), rand_coord(), 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int send_idle[4] = '{0, 75, 0, 16};
    int recv_stall[4] = '{0, 0, 75, 16};
    sb = new();
    points.valid = 1'b0;
    points.radius = '0;
    points.height = '0;
    points.first_point = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no predecessor after reset, then bands of both parities
    send_point(16'sd256, 16'sd0, 1'b0);
    send_point(16'sd512, 16'sd256, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b0);
    // new profile with saturating radius on both ends of the band
    send_point(-16'sd32768, -16'sd32768, 1'b1);
    send_point(-16'sd32768, 16'sd0, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_point(-16'sd256, 16'sd100, 1'b0);
    send_point(16'sh5555, 16'shAAAA, 1'b0);
    send_point(16'shAAAA, 16'sh5555, 1'b0);
    send_point(-16'sd32768, 16'sd1, 1'b0);
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = send_idle[ph];
      stall_pct = recv_stall[ph];
      run_profiles(104, ph == 1);
      wait_for_results();
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending_facets.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d triangles outstanding", sb.pending_facets.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
